### rtl/nonce_registration_table_defines.svh
// ----------------------------------------------------------------------------
// nonce registration table: assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef NONCE_REGISTRATION_TABLE_DEFINES_SVH
`define NONCE_REGISTRATION_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define NRT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nonce registration table: assertion failed");
// checked on every edge, reset included
`define NRT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("nonce registration table: assertion failed");
`else
`define NRT_ASSERT(name, prop)
`define NRT_ASSERT_ALWAYS(name, prop)
`endif

`endif

### rtl/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg
// types and constants shared by the table cells and the top level
// ----------------------------------------------------------------------------
package nrt_pkg;

  localparam int OP_W    = 2;
  localparam int NODE_W  = 16;
  localparam int NONCE_W = 10;
  localparam int AID_W   = 16;

  localparam int TABLE_DEPTH = 16;
  localparam int NONCE_COUNT = 1024;
  // candidate nonce counter, wide enough to hold the nonce count itself
  localparam int CAND_W      = $clog2(NONCE_COUNT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_ASSIGN   = 2'd1,
    OP_CONFIRM  = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [NODE_W-1:0]  node_id;
    logic [NONCE_W-1:0] nonce_in;
    logic [AID_W-1:0]   assigned_id_in;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [NONCE_W-1:0] nonce_out;
    logic [AID_W-1:0]   assigned_id_out;
    logic               table_full;
  } rsp_t;

  // one table entry as handed down the chain on removal
  typedef struct packed {
    logic               valid;
    logic [NODE_W-1:0]  node;
    logic [NONCE_W-1:0] nonce;
    logic [AID_W-1:0]   aid;
  } entry_t;

  // lookup token moving one cell per cycle
  typedef struct packed {
    logic               active;
    logic               hit;
    logic [NONCE_W-1:0] nonce;
    logic [AID_W-1:0]   aid;
  } tok_t;

  // write commands broadcast to all cells
  typedef struct packed {
    logic               load;
    logic               set_aid;
    logic               drop;
    logic [NODE_W-1:0]  node;
    logic [NONCE_W-1:0] nonce;
    logic [AID_W-1:0]   aid;
  } cell_ctl_t;

endpackage

### rtl/nrt_cell.sv
// ----------------------------------------------------------------------------
// nrt_cell
// one table slot: holds an entry, matches the key, passes the lookup token
// ----------------------------------------------------------------------------
module nrt_cell #(
  parameter int DEPTH = nrt_pkg::TABLE_DEPTH,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nrt_pkg::req_t               key,
  input  logic [nrt_pkg::CAND_W-1:0]  probe,
  input  nrt_pkg::cell_ctl_t          ctl,
  input  logic [$clog2(DEPTH)-1:0]    ctl_idx,
  input  nrt_pkg::entry_t             nb_entry,
  output nrt_pkg::entry_t             entry,
  input  nrt_pkg::tok_t               tok_in,
  input  logic [$clog2(DEPTH)-1:0]    tok_idx_in,
  output nrt_pkg::tok_t               tok_out,
  output logic [$clog2(DEPTH)-1:0]    tok_idx_out,
  output logic                        probe_hit
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                        valid;
  logic [nrt_pkg::NODE_W-1:0]  node;
  logic [nrt_pkg::NONCE_W-1:0] nonce;
  logic [nrt_pkg::AID_W-1:0]   aid;
  logic                        match;

  assign entry = '{valid: valid, node: node, nonce: nonce, aid: aid};

  always_comb begin
    match = 1'b0;
    case (key.op)
      nrt_pkg::OP_REGISTER: match = (node == key.node_id);
      nrt_pkg::OP_ASSIGN:   match = (nonce == key.nonce_in);
      nrt_pkg::OP_CONFIRM:  match = (aid == key.assigned_id_in) && (key.assigned_id_in != '0);
      default:              match = 1'b0;
    endcase
    match = match && valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drop && (MY_IDX >= ctl_idx)) begin
      // removal: younger entries move one slot toward the head
      valid <= nb_entry.valid;
      node  <= nb_entry.node;
      nonce <= nb_entry.nonce;
      aid   <= nb_entry.aid;
    end else if (ctl.load && (MY_IDX == ctl_idx)) begin
      valid <= 1'b1;
      node  <= ctl.node;
      nonce <= ctl.nonce;
      aid   <= '0;
    end else if (ctl.set_aid && (MY_IDX == ctl_idx)) begin
      aid <= ctl.aid;
    end
  end

  // first hit on the way wins, so the oldest match is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out     <= '0;
      tok_idx_out <= '0;
    end else if (tok_in.active && !tok_in.hit && match) begin
      tok_out     <= '{active: 1'b1, hit: 1'b1, nonce: nonce, aid: aid};
      tok_idx_out <= MY_IDX;
    end else begin
      tok_out     <= tok_in;
      tok_idx_out <= tok_idx_in;
    end
  end

  always_ff @(posedge clk) begin
    probe_hit <= valid && (probe == nrt_pkg::CAND_W'(nonce));
  end

endmodule

### rtl/nonce_registration_table.sv
// ----------------------------------------------------------------------------
// nonce_registration_table
// registration table in insertion order with lowest free nonce allocation
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// command   in   start & !busy          req (op, node_id, nonce_in, assigned_id_in)
// result    out  done, one cycle        rsp (found, nonce_out, assigned_id_out, table_full)
//
// a lookup token walks the cell chain one slot per cycle: busy while it walks,
// then the result strobe
// a register miss adds a free nonce search, each candidate nonce tried in S_PROBE
// then S_CHECK, at most (entries held + 1) candidates
// one transaction at a time; busy drops in the cycle of done, so the next
// transaction can be taken at the edge that ends the strobe; results cannot stall
// synchronous reset empties the table; no clearing pass is needed
// ----------------------------------------------------------------------------
`include "nonce_registration_table_defines.svh"

module nonce_registration_table #(
  parameter int TABLE_DEPTH = nrt_pkg::TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  nrt_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output nrt_pkg::rsp_t rsp
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [nrt_pkg::CAND_W-1:0] CAND_LAST =
    nrt_pkg::CAND_W'(nrt_pkg::NONCE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN,
    S_PROBE,
    S_CHECK
  } state_t;

  state_t                      state;
  nrt_pkg::req_t               key;
  logic [CW-1:0]               cnt;
  logic [nrt_pkg::CAND_W-1:0]  cand;

  nrt_pkg::tok_t               tok_chain [TABLE_DEPTH+1];
  logic [IW-1:0]               idx_chain [TABLE_DEPTH+1];
  nrt_pkg::entry_t             ent       [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]      probe_vec;
  logic [TABLE_DEPTH-1:0]      valid_vec;
  logic                        probe_any;
  nrt_pkg::tok_t               tok_end;
  nrt_pkg::cell_ctl_t          ctl;
  logic [IW-1:0]               ctl_idx;

  assign busy      = (state != S_IDLE);
  assign probe_any = |probe_vec;
  assign tok_end   = tok_chain[TABLE_DEPTH];

  assign tok_chain[0] = '{active: (state == S_LAUNCH), hit: 1'b0, nonce: '0, aid: '0};
  assign idx_chain[0] = '0;
  assign ent[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nrt_cell #(
      .DEPTH (TABLE_DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .key         (key),
      .probe       (cand),
      .ctl         (ctl),
      .ctl_idx     (ctl_idx),
      .nb_entry    (ent[i+1]),
      .entry       (ent[i]),
      .tok_in      (tok_chain[i]),
      .tok_idx_in  (idx_chain[i]),
      .tok_out     (tok_chain[i+1]),
      .tok_idx_out (idx_chain[i+1]),
      .probe_hit   (probe_vec[i])
    );
    assign valid_vec[i] = ent[i].valid;
  end

  always_comb begin
    ctl     = '0;
    ctl_idx = idx_chain[TABLE_DEPTH];
    if ((state == S_SCAN) && tok_end.active && tok_end.hit) begin
      if (key.op == nrt_pkg::OP_ASSIGN) begin
        ctl.set_aid = 1'b1;
        ctl.aid     = key.assigned_id_in;
      end else if (key.op == nrt_pkg::OP_CONFIRM) begin
        ctl.drop = 1'b1;
      end
    end else if ((state == S_CHECK) && !probe_any) begin
      // append at the tail; only reached with a free slot
      ctl.load  = 1'b1;
      ctl.node  = key.node_id;
      ctl.nonce = cand[nrt_pkg::NONCE_W-1:0];
      ctl_idx   = cnt[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            key   <= req;
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          done  <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!tok_end.active) begin
            done <= 1'b0;
          end else if (tok_end.hit) begin
            rsp   <= '{found: 1'b1, nonce_out: tok_end.nonce,
                       assigned_id_out: tok_end.aid, table_full: 1'b0};
            done  <= 1'b1;
            state <= S_IDLE;
            if (key.op == nrt_pkg::OP_CONFIRM) begin
              cnt <= cnt - 1'b1;
            end
          end else if ((key.op == nrt_pkg::OP_REGISTER) && (cnt != CW'(TABLE_DEPTH))) begin
            done  <= 1'b0;
            cand  <= nrt_pkg::CAND_W'(1);
            state <= S_PROBE;
          end else begin
            // a register miss on a full table flags full, any other miss is all zero
            rsp   <= '{found: 1'b0, nonce_out: '0, assigned_id_out: '0,
                       table_full: (key.op == nrt_pkg::OP_REGISTER)};
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PROBE: begin
          done  <= 1'b0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!probe_any) begin
            cnt   <= cnt + 1'b1;
            rsp   <= '{found: 1'b0, nonce_out: cand[nrt_pkg::NONCE_W-1:0],
                       assigned_id_out: '0, table_full: 1'b0};
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (cand == CAND_LAST) begin
            // every nonce from one upward is taken
            rsp   <= '{found: 1'b0, nonce_out: '0, assigned_id_out: '0, table_full: 1'b1};
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            done  <= 1'b0;
            cand  <= cand + 1'b1;
            state <= S_PROBE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NRT_ASSERT(a_done_single, done |=> !done)
  `NRT_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `NRT_ASSERT(a_count_matches_valid, cnt == $countones(valid_vec))
  `NRT_ASSERT(a_result_exclusive, done |-> !(rsp.found && rsp.table_full))
  `NRT_ASSERT(a_drop_nonempty, ctl.drop |-> (cnt != '0))
  `NRT_ASSERT_ALWAYS(a_write_exclusive, $onehot0({ctl.load, ctl.set_aid, ctl.drop}))

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: nonce registration table testbench
// drives register, assign, confirm and unused-op transactions via the command port,
// predicts every result from a shadow copy of the table and the nonce pool,
// and checks each result strobe field by field in order
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [nrt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 1440;
  localparam int EPISODE_LEN   = 40;
  localparam int NODE_POOL     = 20;
  localparam int AID_POOL      = 12;
  // lowest free search can never go past one more than the table holds
  localparam int NONCE_REACH   = nrt_pkg::TABLE_DEPTH + 1;
  localparam int SETTLE_CYCLES = 120;

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  nrt_pkg::req_t req   = '0;
  logic          busy;
  logic          done;
  nrt_pkg::rsp_t rsp;

  nonce_registration_table DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  nrt_pkg::req_t cmd_q[$];
  nrt_pkg::rsp_t expected_rsp_q[$];
  int   total_items = 0;
  int   n_issued    = 0;
  int   n_accepted  = 0;
  int   n_errors    = 0;

  // shadow table, packed oldest first
  logic [nrt_pkg::NODE_W-1:0]  ent_node  [nrt_pkg::TABLE_DEPTH];
  logic [nrt_pkg::NONCE_W-1:0] ent_nonce [nrt_pkg::TABLE_DEPTH];
  logic [nrt_pkg::AID_W-1:0]   ent_aid   [nrt_pkg::TABLE_DEPTH];
  int                          ent_count = 0;
  bit                          nonce_taken [nrt_pkg::NONCE_COUNT];

  function automatic nrt_pkg::rsp_t predict_rsp(nrt_pkg::req_t r);
    nrt_pkg::rsp_t               o;
    int                          hit;
    int                          i;
    logic [nrt_pkg::NONCE_W-1:0] fresh;
    o     = '0;
    hit   = -1;
    fresh = '0;
    case (r.op)
      nrt_pkg::OP_REGISTER: begin
        for (i = 0; i < ent_count; i++)
          if (hit < 0 && ent_node[i] == r.node_id) hit = i;
        if (hit >= 0) begin
          o.found           = 1'b1;
          o.nonce_out       = ent_nonce[hit];
          o.assigned_id_out = ent_aid[hit];
        end else begin
          for (i = nrt_pkg::NONCE_COUNT - 1; i >= 1; i--)
            if (!nonce_taken[i]) fresh = nrt_pkg::NONCE_W'(i);
          if (ent_count >= nrt_pkg::TABLE_DEPTH || fresh == '0) begin
            o.table_full = 1'b1;
          end else begin
            nonce_taken[fresh]   = 1'b1;
            ent_node[ent_count]  = r.node_id;
            ent_nonce[ent_count] = fresh;
            ent_aid[ent_count]   = '0;
            ent_count++;
            o.nonce_out = fresh;
          end
        end
      end
      nrt_pkg::OP_ASSIGN: begin
        for (i = 0; i < ent_count; i++)
          if (hit < 0 && ent_nonce[i] == r.nonce_in) hit = i;
        if (hit >= 0) begin
          o.found           = 1'b1;
          o.nonce_out       = ent_nonce[hit];
          o.assigned_id_out = ent_aid[hit];
          ent_aid[hit]      = r.assigned_id_in;
        end
      end
      nrt_pkg::OP_CONFIRM: begin
        // assigned id zero never matches
        if (r.assigned_id_in != '0) begin
          for (i = 0; i < ent_count; i++)
            if (hit < 0 && ent_aid[i] == r.assigned_id_in) hit = i;
        end
        if (hit >= 0) begin
          o.found           = 1'b1;
          o.nonce_out       = ent_nonce[hit];
          o.assigned_id_out = ent_aid[hit];
          nonce_taken[ent_nonce[hit]] = 1'b0;
          for (i = hit; i < ent_count - 1; i++) begin
            ent_node[i]  = ent_node[i + 1];
            ent_nonce[i] = ent_nonce[i + 1];
            ent_aid[i]   = ent_aid[i + 1];
          end
          ent_count--;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(string name, logic [nrt_pkg::AID_W-1:0] want_v,
                             logic [nrt_pkg::AID_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      n_errors++;
    end
  endtask

  // driver: hold a transaction until taken, idle at random per phase
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (n_issued < total_items / 3) ? 34 :
               (n_issued < 2 * total_items / 3) ? 85 : 0;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && n_accepted != n_issued)) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req      <= cmd_q.pop_front();
        start    <= 1'b1;
        n_issued <= n_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the result strobe first, then record the accepted transaction
  always @(posedge clk) begin
    nrt_pkg::rsp_t want;
    if (!rst) begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none actual %p",
                   $time, rsp);
          n_errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("found", nrt_pkg::AID_W'(want.found), nrt_pkg::AID_W'(rsp.found));
          check_field("nonce_out", nrt_pkg::AID_W'(want.nonce_out),
                      nrt_pkg::AID_W'(rsp.nonce_out));
          check_field("assigned_id_out", want.assigned_id_out, rsp.assigned_id_out);
          check_field("table_full", nrt_pkg::AID_W'(want.table_full),
                      nrt_pkg::AID_W'(rsp.table_full));
        end
      end
      if (start && !busy) begin
        expected_rsp_q.push_back(predict_rsp(req));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  task automatic push_cmd(logic [nrt_pkg::OP_W-1:0] op, logic [nrt_pkg::NODE_W-1:0] node,
                          logic [nrt_pkg::NONCE_W-1:0] nonce,
                          logic [nrt_pkg::AID_W-1:0] aid);
    nrt_pkg::req_t r;
    r.op             = op;
    r.node_id        = node;
    r.nonce_in       = nonce;
    r.assigned_id_in = aid;
    cmd_q.push_back(r);
  endtask

  initial begin
    logic [nrt_pkg::NODE_W-1:0]  node_pool [NODE_POOL];
    logic [nrt_pkg::AID_W-1:0]   aid_pool  [AID_POOL];
    logic [nrt_pkg::OP_W-1:0]    op;
    logic [nrt_pkg::NODE_W-1:0]  node;
    logic [nrt_pkg::NONCE_W-1:0] nonce;
    logic [nrt_pkg::AID_W-1:0]   aid;
    int                          n_rand;
    int                          mode;
    int                          roll;
    bit                          noise;

    // directed part
    push_cmd(OP_UNUSED,            16'hFFFF, 10'h3FF, 16'hFFFF);
    push_cmd(nrt_pkg::OP_CONFIRM,  16'h0000, 10'h000, 16'h0000);
    push_cmd(nrt_pkg::OP_ASSIGN,   16'h0000, 10'h000, 16'h0001);
    push_cmd(nrt_pkg::OP_REGISTER, 16'h0000, 10'h000, 16'h0000);
    push_cmd(nrt_pkg::OP_REGISTER, 16'hFFFF, 10'h3FF, 16'hFFFF);
    push_cmd(nrt_pkg::OP_REGISTER, 16'h0000, 10'h000, 16'h0000);
    push_cmd(nrt_pkg::OP_ASSIGN,   16'h0000, 10'h001, 16'hFFFF);
    push_cmd(nrt_pkg::OP_ASSIGN,   16'h0000, 10'h3FF, 16'h0005);
    push_cmd(nrt_pkg::OP_ASSIGN,   16'hFFFF, 10'h000, 16'h0007);
    push_cmd(nrt_pkg::OP_REGISTER, 16'h0000, 10'h000, 16'h0000);
    // unassigned entry present, but assigned id zero must miss
    push_cmd(nrt_pkg::OP_CONFIRM,  16'h0000, 10'h000, 16'h0000);
    push_cmd(nrt_pkg::OP_CONFIRM,  16'h0000, 10'h000, 16'h1234);
    push_cmd(nrt_pkg::OP_CONFIRM,  16'h0000, 10'h000, 16'hFFFF);
    // freed nonce below a held one is handed out again
    push_cmd(nrt_pkg::OP_REGISTER, 16'h1234, 10'h000, 16'h0000);
    push_cmd(nrt_pkg::OP_ASSIGN,   16'h0000, 10'h002, 16'h0001);
    push_cmd(nrt_pkg::OP_ASSIGN,   16'h0000, 10'h001, 16'h0001);
    // duplicate ids: oldest goes first
    push_cmd(nrt_pkg::OP_CONFIRM,  16'h0000, 10'h000, 16'h0001);
    push_cmd(nrt_pkg::OP_CONFIRM,  16'h0000, 10'h000, 16'h0001);

    // random part: small pools so lookups hit and the table fills and drains
    for (int i = 0; i < NODE_POOL; i++) node_pool[i] = nrt_pkg::NODE_W'($urandom);
    node_pool[0] = '0;
    node_pool[1] = '1;
    for (int i = 0; i < AID_POOL; i++)
      aid_pool[i] = nrt_pkg::AID_W'($urandom_range(65535, 1));
    aid_pool[0] = '1;
    aid_pool[1] = nrt_pkg::AID_W'(1);

    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      // 0 mostly register, 1 balanced, 2 mostly assign and confirm
      mode = $urandom_range(2);
      for (int k = 0; k < EPISODE_LEN && n_rand < RANDOM_ITEMS; k++) begin
        roll  = $urandom_range(99);
        noise = ($urandom_range(99) < 8);
        case (mode)
          0: op = (roll < 70) ? nrt_pkg::OP_REGISTER :
                  (roll < 90) ? nrt_pkg::OP_ASSIGN : nrt_pkg::OP_CONFIRM;
          1: op = (roll < 40) ? nrt_pkg::OP_REGISTER :
                  (roll < 70) ? nrt_pkg::OP_ASSIGN : nrt_pkg::OP_CONFIRM;
          default: op = (roll < 15) ? nrt_pkg::OP_REGISTER :
                        (roll < 55) ? nrt_pkg::OP_ASSIGN : nrt_pkg::OP_CONFIRM;
        endcase
        if (noise && $urandom_range(3) == 0) op = OP_UNUSED;
        node  = noise ? nrt_pkg::NODE_W'($urandom) : node_pool[$urandom_range(NODE_POOL - 1)];
        nonce = noise ? nrt_pkg::NONCE_W'($urandom) :
                        nrt_pkg::NONCE_W'($urandom_range(NONCE_REACH));
        if (noise) aid = nrt_pkg::AID_W'($urandom);
        else if ($urandom_range(15) == 0) aid = '0;
        else aid = aid_pool[$urandom_range(AID_POOL - 1)];
        push_cmd(op, node, nonce, aid);
        n_rand++;
      end
    end
    total_items = cmd_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_accepted == total_items);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/nrt_pkg.sv
rtl/nrt_cell.sv
rtl/nonce_registration_table.sv
tb/sv/tb.sv
